FILE: sv/hed_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hed_pkg: shared types and constants for the HTML entity decoder
// Holds the parse phases, the queue entry format, the front state codes and
// the table of named references.
// ----------------------------------------------------------------------------
package hed_pkg;

	// Parse phase of an open reference.
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_NAME,
		PH_HASH,
		PH_HASHX,
		PH_DEC,
		PH_HEX
	} phase_t;

	// Kind of work handed from the front to the back.
	typedef enum logic [1:0] {
		OP_LIT,
		OP_CP,
		OP_END
	} op_kind_t;

	// One queue entry: a literal byte, a code point, or an end-of-item mark.
	typedef struct packed {
		op_kind_t    kind;
		logic [20:0] data;
	} op_t;

	// Front sequencer states.
	typedef enum logic [2:0] {
		F_READY,
		F_LIT,
		F_TAKE,
		F_REPLAY,
		F_CP,
		F_CLOSE
	} fstate_t;

	localparam logic [20:0] CP_MAX  = 21'h10FFFF;
	localparam logic [20:0] CP_REPL = 21'h00FFFD;
	localparam int NAME_COUNT = 24;
	localparam int NAME_MAX   = 7;

	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_SEMI = 8'h3B;

	// Named references, text right-aligned (last character in the low byte).
	localparam logic [55:0] NAME_TXT [NAME_COUNT] = '{
		"Tab", "NewLine", "colon", "sol", "excl", "quot", "apos", "lt",
		"gt", "amp", "lpar", "rpar", "comma", "period", "equals", "plus",
		"num", "quest", "semi", "bsol", "grave", "dollar", "lowbar", "nbsp"
	};
	localparam logic [2:0] NAME_LENS [NAME_COUNT] = '{
		3'd3, 3'd7, 3'd5, 3'd3, 3'd4, 3'd4, 3'd4, 3'd2,
		3'd2, 3'd3, 3'd4, 3'd4, 3'd5, 3'd6, 3'd6, 3'd4,
		3'd3, 3'd5, 3'd4, 3'd4, 3'd5, 3'd6, 3'd6, 3'd4
	};
	localparam logic [7:0] NAME_CP [NAME_COUNT] = '{
		8'h09, 8'h0A, 8'h3A, 8'h2F, 8'h21, 8'h22, 8'h27, 8'h3C,
		8'h3E, 8'h26, 8'h28, 8'h29, 8'h2C, 8'h2E, 8'h3D, 8'h2B,
		8'h23, 8'h3F, 8'h3B, 8'h5C, 8'h60, 8'h24, 8'h5F, 8'hA0
	};

	// Character i (from the start) of named reference k.
	function automatic logic [7:0] name_char(input int k, input int i);
		logic [55:0] t;
		int          sh;
		sh = 8 * (int'(NAME_LENS[k]) - 1 - i);
		if (sh < 0) begin
			return 8'h00;
		end
		t = NAME_TXT[k] >> sh;
		return t[7:0];
	endfunction

endpackage
`default_nettype wire

FILE: sv/hed_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hed_queue: four-entry queue between the front and the back
// Decouples the parser from the byte emitter so each side stalls on its own.
// ----------------------------------------------------------------------------
module hed_queue (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            push,
	input  hed_pkg::op_t   push_op,
	output logic           not_full,
	input  wire            pop,
	output hed_pkg::op_t   head_op,
	output logic           not_empty
);
	import hed_pkg::*;

	op_t        mem_q [4];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] cnt_q;

	assign not_full  = (cnt_q != 3'd4);
	assign not_empty = (cnt_q != 3'd0);
	assign head_op   = mem_q[rd_q];

	// Storage is written at the tail only.
	always_ff @(posedge clk) begin
		if (push && not_full) begin
			mem_q[wr_q] <= push_op;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 2'd0;
			rd_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			if (push && not_full) begin
				wr_q <= wr_q + 2'd1;
			end
			if (pop && not_empty) begin
				rd_q <= rd_q + 2'd1;
			end
			case ({push && not_full, pop && not_empty})
				2'b10:   cnt_q <= cnt_q + 3'd1;
				2'b01:   cnt_q <= cnt_q - 3'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: sv/hed_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hed_front: reference parser
// Accepts one text byte, tracks the open reference and queues the work for
// the back: literal bytes, replays, decoded code points and an end mark.
// ----------------------------------------------------------------------------
module hed_front #(
	parameter int PENDING_DEPTH = 9
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            s_tvalid,
	output logic           s_tready,
	input  wire [7:0]      s_tdata,
	input  wire            s_tlast,
	output logic           push,
	output hed_pkg::op_t   push_op,
	input  wire            q_ready
);
	import hed_pkg::*;

	localparam int IW = $clog2(PENDING_DEPTH);
	localparam int CW = $clog2(PENDING_DEPTH + 1);

	fstate_t        state_q, state_d;
	phase_t         phase_q, phase_d;
	logic [7:0]     pend_q [PENDING_DEPTH];
	logic [CW-1:0]  pcount_q;
	logic [IW-1:0]  idx_q;
	logic [20:0]    acc_q;
	logic           ovf_q;
	logic [7:0]     byte_q;
	logic           last_q;
	logic [20:0]    cp_q;
	fstate_t        cpn_q, cpn_d;
	fstate_t        repn_q, repn_d;

	logic           item_ld, do_close, phase_set, pend_wr, acc_add, add_hex;
	logic           cp_ld, idx_inc, idx_clr;
	logic [7:0]     pend_byte;
	logic [3:0]     digit;
	logic [20:0]    cp_d;

	// Classification of the incoming byte.
	logic [7:0] b;
	logic       is_dec, is_hex, is_alnum;
	logic [3:0] dec_val, hex_val;
	assign b = s_tdata;
	always_comb begin
		is_dec   = (b >= "0") && (b <= "9");
		is_alnum = is_dec || ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
		dec_val  = 4'(b - "0");
		is_hex   = 1'b1;
		if (is_dec) begin
			hex_val = dec_val;
		end else if ((b >= "a") && (b <= "f")) begin
			hex_val = 4'(b - "a" + 8'd10);
		end else if ((b >= "A") && (b <= "F")) begin
			hex_val = 4'(b - "A" + 8'd10);
		end else begin
			hex_val = 4'd0;
			is_hex  = 1'b0;
		end
	end

	// Named reference lookup over the stored name characters.
	logic       hit;
	logic [7:0] hit_cp;
	logic [CW-1:0] name_len;
	always_comb begin
		logic ok;
		hit      = 1'b0;
		hit_cp   = 8'h00;
		name_len = pcount_q - CW'(1);
		for (int k = 0; k < NAME_COUNT; k++) begin
			ok = (pcount_q >= CW'(2)) && (name_len == CW'(NAME_LENS[k]));
			for (int i = 0; i < NAME_MAX; i++) begin
				if ((i < int'(NAME_LENS[k])) && (pend_q[i + 1] != name_char(k, i))) begin
					ok = 1'b0;
				end
			end
			if (ok) begin
				hit    = 1'b1;
				hit_cp = NAME_CP[k];
			end
		end
	end

	// Next state and queue commands.
	always_comb begin
		state_d   = state_q;
		phase_d   = phase_q;
		cpn_d     = cpn_q;
		repn_d    = repn_q;
		item_ld   = 1'b0;
		do_close  = 1'b0;
		phase_set = 1'b0;
		pend_wr   = 1'b0;
		pend_byte = s_tdata;
		acc_add   = 1'b0;
		add_hex   = 1'b0;
		digit     = dec_val;
		cp_ld     = 1'b0;
		cp_d      = acc_q;
		idx_inc   = 1'b0;
		idx_clr   = 1'b0;
		push      = 1'b0;
		push_op   = '{kind: OP_END, data: 21'd0};
		s_tready  = (state_q == F_READY);
		case (state_q)
			F_READY: begin
				if (s_tvalid) begin
					item_ld = 1'b1;
					state_d = F_CLOSE;
					case (phase_q)
						PH_IDLE: begin
							if (b == CH_AMP) begin
								do_close  = 1'b1;
								pend_wr   = 1'b1;
								phase_set = 1'b1;
								phase_d   = PH_NAME;
							end else begin
								state_d = F_LIT;
							end
						end
						PH_NAME: begin
							if ((pcount_q == CW'(1)) && (b == CH_HASH)) begin
								pend_wr   = 1'b1;
								phase_set = 1'b1;
								phase_d   = PH_HASH;
							end else if (b == CH_SEMI) begin
								if (hit) begin
									cp_ld    = 1'b1;
									cp_d     = {13'd0, hit_cp};
									do_close = 1'b1;
									cpn_d    = F_CLOSE;
									state_d  = F_CP;
								end else begin
									repn_d  = F_TAKE;
									state_d = F_REPLAY;
								end
							end else if (is_alnum && (pcount_q < CW'(NAME_MAX + 1)) &&
									(pcount_q < CW'(PENDING_DEPTH))) begin
								pend_wr = 1'b1;
							end else begin
								repn_d  = F_TAKE;
								state_d = F_REPLAY;
							end
						end
						PH_HASH: begin
							if ((b == "x") || (b == "X")) begin
								pend_wr   = 1'b1;
								phase_set = 1'b1;
								phase_d   = PH_HASHX;
							end else if (is_dec) begin
								phase_set = 1'b1;
								phase_d   = PH_DEC;
								acc_add   = 1'b1;
							end else begin
								repn_d  = F_TAKE;
								state_d = F_REPLAY;
							end
						end
						PH_HASHX: begin
							if (is_hex) begin
								phase_set = 1'b1;
								phase_d   = PH_HEX;
								acc_add   = 1'b1;
								add_hex   = 1'b1;
								digit     = hex_val;
							end else begin
								repn_d  = F_TAKE;
								state_d = F_REPLAY;
							end
						end
						PH_DEC, PH_HEX: begin
							add_hex = (phase_q == PH_HEX);
							digit   = add_hex ? hex_val : dec_val;
							if (add_hex ? is_hex : is_dec) begin
								acc_add = 1'b1;
							end else begin
								cp_ld    = 1'b1;
								do_close = 1'b1;
								cpn_d    = (b == CH_SEMI) ? F_CLOSE : F_TAKE;
								state_d  = F_CP;
							end
						end
						default: begin
							phase_set = 1'b1;
							phase_d   = PH_IDLE;
							state_d   = F_TAKE;
						end
					endcase
				end
			end
			F_LIT: begin
				push    = 1'b1;
				push_op = '{kind: OP_LIT, data: {13'd0, byte_q}};
				if (q_ready) begin
					state_d = F_CLOSE;
				end
			end
			F_TAKE: begin
				pend_byte = byte_q;
				if (byte_q == CH_AMP) begin
					do_close  = 1'b1;
					pend_wr   = 1'b1;
					phase_set = 1'b1;
					phase_d   = PH_NAME;
					state_d   = F_CLOSE;
				end else begin
					push    = 1'b1;
					push_op = '{kind: OP_LIT, data: {13'd0, byte_q}};
					if (q_ready) begin
						state_d = F_CLOSE;
					end
				end
			end
			F_REPLAY: begin
				push    = 1'b1;
				push_op = '{kind: OP_LIT, data: {13'd0, pend_q[idx_q]}};
				if (q_ready) begin
					if (CW'(idx_q) == pcount_q - CW'(1)) begin
						do_close = 1'b1;
						idx_clr  = 1'b1;
						state_d  = repn_q;
					end else begin
						idx_inc = 1'b1;
					end
				end
			end
			F_CP: begin
				push    = 1'b1;
				push_op = '{kind: OP_CP, data: cp_q};
				if (q_ready) begin
					state_d = cpn_q;
				end
			end
			F_CLOSE: begin
				if (last_q && ((phase_q == PH_DEC) || (phase_q == PH_HEX))) begin
					cp_ld    = 1'b1;
					do_close = 1'b1;
					cpn_d    = F_CLOSE;
					state_d  = F_CP;
				end else if (last_q && (phase_q != PH_IDLE)) begin
					repn_d  = F_CLOSE;
					state_d = F_REPLAY;
				end else begin
					push = 1'b1;
					if (q_ready) begin
						state_d = F_READY;
					end
				end
			end
			default: begin
				state_d = F_READY;
			end
		endcase
	end

	// Accumulator step: one digit, with the sticky overflow to U+FFFD.
	logic [25:0] acc_mul, acc_sum;
	always_comb begin
		acc_mul = add_hex ? {1'b0, acc_q, 4'd0} : ({2'b0, acc_q, 3'd0} + {4'd0, acc_q, 1'b0});
		acc_sum = acc_mul + 26'(digit);
	end

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_READY;
		end else begin
			state_q <= state_d;
		end
	end

	// Parse state and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			pcount_q <= '0;
			idx_q    <= '0;
			acc_q    <= 21'd0;
			ovf_q    <= 1'b0;
			cpn_q    <= F_CLOSE;
			repn_q   <= F_CLOSE;
		end else begin
			cpn_q  <= cpn_d;
			repn_q <= repn_d;
			if (do_close) begin
				// Closing a reference may open the next one in the same cycle.
				phase_q  <= phase_set ? phase_d : PH_IDLE;
				pcount_q <= pend_wr ? CW'(1) : '0;
				acc_q    <= 21'd0;
				ovf_q    <= 1'b0;
			end else begin
				if (phase_set) begin
					phase_q <= phase_d;
				end
				if (pend_wr && (pcount_q < CW'(PENDING_DEPTH))) begin
					pcount_q <= pcount_q + CW'(1);
				end
				if (acc_add && !ovf_q) begin
					if (acc_sum > {5'd0, CP_MAX}) begin
						ovf_q <= 1'b1;
						acc_q <= CP_REPL;
					end else begin
						acc_q <= acc_sum[20:0];
					end
				end
			end
			if (idx_clr) begin
				idx_q <= '0;
			end else if (idx_inc) begin
				idx_q <= idx_q + IW'(1);
			end
		end
	end

	// Pending bytes and item payload.
	always_ff @(posedge clk) begin
		if (pend_wr) begin
			if (do_close) begin
				pend_q[0] <= pend_byte;
			end else if (pcount_q < CW'(PENDING_DEPTH)) begin
				pend_q[pcount_q[IW-1:0]] <= pend_byte;
			end
		end
		if (item_ld) begin
			byte_q <= s_tdata;
			last_q <= s_tlast;
		end
		if (cp_ld) begin
			cp_q <= cp_d;
		end
	end

endmodule
`default_nettype wire

FILE: sv/hed_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hed_back: byte emitter
// Expands queued work into output bytes (UTF-8 for code points), applies the
// normalize filter and marks the last byte of each item.
// ----------------------------------------------------------------------------
module hed_back (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            normalize_mode,
	input  hed_pkg::op_t   head_op,
	input  wire            q_valid,
	output logic           pop,
	output logic           m_tvalid,
	input  wire            m_tready,
	output logic [7:0]     m_tdata,
	output logic           m_tlast
);
	import hed_pkg::*;

	logic       busy_q;
	op_t        op_q;
	logic [1:0] k_q;
	logic       held_v_q;
	logic [7:0] held_q;
	logic       out_v_q;
	logic [7:0] out_d_q;
	logic       out_l_q;

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_d_q;
	assign m_tlast  = out_l_q;

	// UTF-8 expansion of the current entry.
	logic [20:0] cp;
	logic [1:0]  n_last;
	logic [7:0]  u [4];
	always_comb begin
		cp = op_q.data;
		u[0] = cp[7:0];
		u[1] = 8'h00;
		u[2] = 8'h00;
		u[3] = 8'h00;
		n_last = 2'd0;
		if ((op_q.kind == OP_CP) && (cp >= 21'h80)) begin
			if (cp < 21'h800) begin
				u[0] = {3'b110, cp[10:6]};
				u[1] = {2'b10, cp[5:0]};
				n_last = 2'd1;
			end else if (cp < 21'h10000) begin
				u[0] = {4'b1110, cp[15:12]};
				u[1] = {2'b10, cp[11:6]};
				u[2] = {2'b10, cp[5:0]};
				n_last = 2'd2;
			end else begin
				u[0] = {5'b11110, cp[20:18]};
				u[1] = {2'b10, cp[17:12]};
				u[2] = {2'b10, cp[11:6]};
				u[3] = {2'b10, cp[5:0]};
				n_last = 2'd3;
			end
		end
	end

	// Normalize filter on the candidate byte.
	logic [7:0] c, c_fold;
	logic       keep;
	always_comb begin
		c      = u[k_q];
		keep   = !(normalize_mode && ((c <= 8'h20) || (c == 8'h7F)));
		c_fold = (normalize_mode && (c >= "A") && (c <= "Z")) ? (c + 8'd32) : c;
	end

	// One candidate byte per cycle unless a held byte waits on a stalled output;
	// a kept byte is held until the next one or the end mark decides its last flag.
	logic slot, done, adv, send, send_l, held_ld, held_clr;
	always_comb begin
		slot     = !out_v_q || m_tready;
		done     = 1'b0;
		adv      = 1'b0;
		send     = 1'b0;
		send_l   = 1'b0;
		held_ld  = 1'b0;
		held_clr = 1'b0;
		if (busy_q) begin
			if (op_q.kind == OP_END) begin
				if (!held_v_q) begin
					done = 1'b1;
				end else if (slot) begin
					send     = 1'b1;
					send_l   = 1'b1;
					held_clr = 1'b1;
					done     = 1'b1;
				end
			end else if (!keep || !held_v_q || slot) begin
				if (keep) begin
					send    = held_v_q;
					held_ld = 1'b1;
				end
				if (k_q == n_last) begin
					done = 1'b1;
				end else begin
					adv = 1'b1;
				end
			end
		end
		pop = q_valid && (!busy_q || done);
	end

	// Entry tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			k_q      <= 2'd0;
			held_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				k_q    <= 2'd0;
			end else if (done) begin
				busy_q <= 1'b0;
			end else if (adv) begin
				k_q <= k_q + 2'd1;
			end
			if (held_ld) begin
				held_v_q <= 1'b1;
			end else if (held_clr) begin
				held_v_q <= 1'b0;
			end
			if (send) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (pop) begin
			op_q <= head_op;
		end
		if (held_ld) begin
			held_q <= c_fold;
		end
		if (send) begin
			out_d_q <= held_q;
			out_l_q <= send_l;
		end
	end

endmodule
`default_nettype wire

FILE: sv/html_entity_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// html_entity_decoder: streaming HTML character reference decoder
// Decodes numeric and named references to UTF-8, replays failed references
// as literal text and optionally drops control, space and delete bytes and folds uppercase ASCII.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload                               Handshake
//  s_*       in         tdata=in_byte, tlast=in_last          tvalid/tready
//  m_*       out        tdata=out_byte, tlast=out_run_last    tvalid/tready
//  cfg_*     in         cfg_wdata=normalize_mode              cfg_we
//
// The parser accepts a byte and then queues its entries in order: a plain byte
// queues its literal and an end mark, a byte that only extends a reference
// queues just the end mark, and a replay queues one literal per pending byte.
// The emitter handles candidate bytes and end marks in turn. A four-entry
// queue lets either side stall alone; a full queue or a stalled output holds
// the parser. Reset clears all control state.
// ----------------------------------------------------------------------------
module html_entity_decoder #(
	parameter int PENDING_DEPTH = 9
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire [7:0]  s_tdata,   // [7:0] in_byte
	input  wire        s_tlast,
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tlast,
	input  wire        cfg_we,
	input  wire        cfg_wdata
);
	import hed_pkg::*;

	logic normalize_q;
	logic push, q_ready, pop, q_valid;
	op_t  push_op, head_op;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normalize_q <= 1'b0;
		end else if (cfg_we) begin
			normalize_q <= cfg_wdata;
		end
	end

	hed_front #(.PENDING_DEPTH(PENDING_DEPTH)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.push     (push),
		.push_op  (push_op),
		.q_ready  (q_ready)
	);

	hed_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_op   (push_op),
		.not_full  (q_ready),
		.pop       (pop),
		.head_op   (head_op),
		.not_empty (q_valid)
	);

	hed_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.normalize_mode (normalize_q),
		.head_op        (head_op),
		.q_valid        (q_valid),
		.pop            (pop),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tlast        (m_tlast)
	);

endmodule
`default_nettype wire

FILE: sv/hed_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hed_checker: port-level checks for the HTML entity decoder
// Watches the stream ports and the configuration port over time.
// ----------------------------------------------------------------------------
module hed_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       s_tvalid,
	input wire       s_tready,
	input wire       m_tvalid,
	input wire       m_tready,
	input wire [7:0] m_tdata,
	input wire       m_tlast,
	input wire       cfg_we,
	input wire       cfg_wdata
);
	logic mode_q;

	// Track the normalize setting from the write port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	// A stalled output item holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output item changed while stalled");

	// In normalize mode no control, space, delete or uppercase byte leaves.
	a_norm: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && mode_q |-> (m_tdata > 8'h20) && (m_tdata != 8'h7F) &&
			!((m_tdata >= 8'h41) && (m_tdata <= 8'h5A)))
		else $error("normalize filter let a byte through");

	// One item at a time: the input closes after an accept.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted back to back");

endmodule

bind html_entity_decoder hed_checker u_hed_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tlast   (m_tlast),
	.cfg_we    (cfg_we),
	.cfg_wdata (cfg_wdata)
);
`default_nettype wire
